>>> rtl/local_interrupt_timer_registers_defines.svh
// assertion helpers for the local interrupt timer block
`ifndef LOCAL_INTERRUPT_TIMER_REGISTERS_DEFINES_SVH
`define LOCAL_INTERRUPT_TIMER_REGISTERS_DEFINES_SVH

// checked only outside reset
`define LIT_ASSERT_ON(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define LIT_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/lit_pkg.sv
package lit_pkg;

  localparam int COUNT_WIDTH = 32;

  typedef enum logic [1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_code_t;

  localparam logic [5:0] IDX_ID   = 6'h02;
  localparam logic [5:0] IDX_TPR  = 6'h08;
  localparam logic [5:0] IDX_SVR  = 6'h0F;
  localparam logic [5:0] IDX_LVT  = 6'h32;
  localparam logic [5:0] IDX_INIT = 6'h38;
  localparam logic [5:0] IDX_CUR  = 6'h39;
  localparam logic [5:0] IDX_DIV  = 6'h3E;

  localparam int LVT_MASK_BIT     = 16;
  localparam int LVT_PERIODIC_BIT = 17;
  localparam int SVR_ENABLE_BIT   = 8;

  typedef struct packed {
    cmd_code_t   command;
    logic [5:0]  reg_index;
    logic [31:0] write_data;
  } cmd_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_valid;
    logic [7:0]  irq_vector;
  } result_t;

  // divide register bits 3,1,0 select 2..128, all ones selects 1
  function automatic logic [7:0] divisor(logic [3:0] code);
    logic [2:0] sel;
    sel = {code[3], code[1:0]};
    if (sel == 3'd7) divisor = 8'd1;
    else divisor = 8'd2 << sel;
  endfunction

endpackage

>>> rtl/lit_if.sv
interface lit_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  reg_index;
  logic [31:0] write_data;
  modport source (output valid, command, reg_index, write_data, input ready);
  modport sink (input valid, command, reg_index, write_data, output ready);
endinterface

interface lit_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_valid;
  logic [7:0]  irq_vector;
  modport source (output valid, read_data, irq_valid, irq_vector, input ready);
  modport sink (input valid, read_data, irq_valid, irq_vector, output ready);
endinterface

interface lit_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/lit_core.sv
module lit_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  lit_pkg::cmd_t    beat,
  input  logic [7:0]       unit_id,
  output lit_pkg::result_t result
);

  logic [7:0]                     timer_vector, timer_vector_next;
  logic                           timer_masked, timer_masked_next;
  logic                           timer_periodic, timer_periodic_next;
  logic [lit_pkg::COUNT_WIDTH-1:0] initial_count, initial_count_next;
  logic [lit_pkg::COUNT_WIDTH-1:0] current_count, current_count_next;
  logic [lit_pkg::COUNT_WIDTH-1:0] count_dec;
  logic [3:0]                     divide_code, divide_code_next;
  logic [6:0]                     prescale_count, prescale_count_next;
  logic [7:0]                     spurious_vector, spurious_vector_next;
  logic                           unit_enabled, unit_enabled_next;
  logic [7:0]                     task_priority, task_priority_next;
  logic [7:0]                     prescale_inc;

  assign prescale_inc = {1'b0, prescale_count} + 8'd1;
  assign count_dec    = current_count - {{(lit_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};

  always_comb begin
    timer_vector_next    = timer_vector;
    timer_masked_next    = timer_masked;
    timer_periodic_next  = timer_periodic;
    initial_count_next   = initial_count;
    current_count_next   = current_count;
    divide_code_next     = divide_code;
    prescale_count_next  = prescale_count;
    spurious_vector_next = spurious_vector;
    unit_enabled_next    = unit_enabled;
    task_priority_next   = task_priority;
    result               = '0;
    case (beat.command)
      lit_pkg::CMD_READ: begin
        case (beat.reg_index)
          lit_pkg::IDX_ID:   result.read_data = {unit_id, 24'd0};
          lit_pkg::IDX_TPR:  result.read_data = {24'd0, task_priority};
          lit_pkg::IDX_SVR: begin
            result.read_data = {23'd0, unit_enabled, spurious_vector};
          end
          lit_pkg::IDX_LVT: begin
            result.read_data = {14'd0, timer_periodic, timer_masked, 8'd0, timer_vector};
          end
          lit_pkg::IDX_INIT: result.read_data = 32'(initial_count);
          lit_pkg::IDX_CUR:  result.read_data = 32'(current_count);
          lit_pkg::IDX_DIV:  result.read_data = {28'd0, divide_code};
          default:           result.read_data = '0;
        endcase
      end
      lit_pkg::CMD_WRITE: begin
        case (beat.reg_index)
          lit_pkg::IDX_TPR: task_priority_next = beat.write_data[7:0];
          lit_pkg::IDX_SVR: begin
            spurious_vector_next = beat.write_data[7:0];
            unit_enabled_next    = beat.write_data[lit_pkg::SVR_ENABLE_BIT];
          end
          lit_pkg::IDX_LVT: begin
            timer_vector_next   = beat.write_data[7:0];
            timer_masked_next   = beat.write_data[lit_pkg::LVT_MASK_BIT];
            timer_periodic_next = beat.write_data[lit_pkg::LVT_PERIODIC_BIT];
          end
          lit_pkg::IDX_INIT: begin
            initial_count_next  = beat.write_data[lit_pkg::COUNT_WIDTH-1:0];
            current_count_next  = beat.write_data[lit_pkg::COUNT_WIDTH-1:0];
            prescale_count_next = '0;
          end
          lit_pkg::IDX_DIV: begin
            divide_code_next = {beat.write_data[3], 1'b0, beat.write_data[1:0]};
          end
          default: ;
        endcase
      end
      lit_pkg::CMD_TICK: begin
        if (current_count != '0) begin
          if (prescale_inc >= lit_pkg::divisor(divide_code)) begin
            prescale_count_next = '0;
            current_count_next  = count_dec;
            if (count_dec == '0) begin
              if (!timer_masked && unit_enabled) begin
                result.irq_valid  = 1'b1;
                result.irq_vector = timer_vector;
              end
              if (timer_periodic) current_count_next = initial_count;
            end
          end else begin
            prescale_count_next = prescale_inc[6:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer_vector    <= '0;
      timer_masked    <= 1'b1;
      timer_periodic  <= 1'b0;
      initial_count   <= '0;
      current_count   <= '0;
      divide_code     <= '0;
      prescale_count  <= '0;
      spurious_vector <= 8'hFF;
      unit_enabled    <= 1'b0;
      task_priority   <= '0;
    end else if (step) begin
      timer_vector    <= timer_vector_next;
      timer_masked    <= timer_masked_next;
      timer_periodic  <= timer_periodic_next;
      initial_count   <= initial_count_next;
      current_count   <= current_count_next;
      divide_code     <= divide_code_next;
      prescale_count  <= prescale_count_next;
      spurious_vector <= spurious_vector_next;
      unit_enabled    <= unit_enabled_next;
      task_priority   <= task_priority_next;
    end
  end

endmodule

>>> rtl/local_interrupt_timer_registers.sv
// path: a beat accepted into the input register is offered from the result register
// throughput: one beat per cycle while rsp.ready stays high, set by the input register
//   feeding the register file and timer logic straight into the result register
// reset: synchronous, clears both stage valids and puts every register-file register at
//   its documented value (lvt masked, svr vector 0xff, counts zero)
`include "local_interrupt_timer_registers_defines.svh"

module local_interrupt_timer_registers (
  input logic      clk,
  input logic      rst,
  lit_cmd_if.sink  cmd,
  lit_rsp_if.source rsp,
  lit_cfg_if.sink  cfg
);

  // input stage
  logic             in_valid;
  lit_pkg::cmd_t    in_beat;
  // result stage
  logic             out_valid;
  lit_pkg::result_t out_result;
  lit_pkg::result_t core_result;

  logic       advance;
  logic [7:0] unit_id;

  // the input stage moves on whenever the result register is free or drains
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign cmd.ready = !in_valid || advance;

  // configuration is taken every cycle
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_id <= '0;
    end else if (cfg.valid) begin
      unit_id <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_beat.command    <= lit_pkg::cmd_code_t'(cmd.command);
      in_beat.reg_index  <= cmd.reg_index;
      in_beat.write_data <= cmd.write_data;
    end
  end

  // register file and timer; state commits only when the beat moves on
  lit_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .beat    (in_beat),
    .unit_id (unit_id),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_result.read_data;
  assign rsp.irq_valid  = out_result.irq_valid;
  assign rsp.irq_vector = out_result.irq_vector;

  // an interrupt only comes from a tick, which never carries read data
  `LIT_ASSERT_ON(a_irq_no_data,
                 rsp.valid && rsp.irq_valid |-> rsp.read_data == 32'd0,
                 "irq beat carries read data")
  // back pressure on the input only when both stages hold a beat
  `LIT_ASSERT_ON(a_stall_full,
                 !cmd.ready |-> in_valid && out_valid && !rsp.ready,
                 "input stalled with a free stage")
  // nothing is offered right after reset
  `LIT_ASSERT_ALWAYS(a_reset_empty,
                     $past(rst) |-> !rsp.valid && !in_valid,
                     "pipeline not empty after reset")

endmodule

>>> test/tb_local_interrupt_timer_registers.sv
module tb_local_interrupt_timer_registers;

  // command code 3 is reserved: the block must answer with an all-zero result
  localparam logic [1:0] CMD_RESERVED = 2'd3;
  // divide select {b3,b1,b0} of all ones means divide by one
  localparam logic [2:0] SEL_DIV_BY_ONE = 3'b111;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_BEATS = 1750;
  // spare cycles waited after the last owed result, to let the pipe settle
  localparam int DRAIN_CYCLES = 4;
  localparam int LONG_HOLD = 250;

  logic clk;
  logic rst;

  lit_cmd_if cmd_if ();
  lit_rsp_if rsp_if ();
  lit_cfg_if cfg_if ();

  local_interrupt_timer_registers i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if),
    .cfg (cfg_if)
  );

  // mirror of the register file and timer, plus the queue of results owed
  class irq_timer_scoreboard;
    logic [7:0]                      unit_id;
    logic [7:0]                      vector;
    bit                              masked;
    bit                              periodic;
    logic [lit_pkg::COUNT_WIDTH-1:0] init_cnt;
    logic [lit_pkg::COUNT_WIDTH-1:0] cur_cnt;
    logic [3:0]                      div_code;
    logic [6:0]                      prescale;
    logic [7:0]                      spur_vec;
    bit                              enabled;
    logic [7:0]                      tpr;
    lit_pkg::result_t                owed_q[$];
    int errors, n_reads, n_writes, n_ticks, n_other, n_irqs, n_checked;

    function new();
      unit_id  = 8'h00;
      vector   = 8'h00;
      masked   = 1'b1;
      periodic = 1'b0;
      init_cnt = '0;
      cur_cnt  = '0;
      div_code = 4'h0;
      prescale = 7'h00;
      spur_vec = 8'hFF;
      enabled  = 1'b0;
      tpr      = 8'h00;
    endfunction

    // ticks needed per count step for the current divide setting
    function int unsigned tick_period();
      logic [2:0] sel;
      sel = {div_code[3], div_code[1:0]};
      return (sel == SEL_DIV_BY_ONE) ? 1 : (2 << sel);
    endfunction

    function lit_pkg::result_t timer_result(lit_pkg::cmd_t c);
      lit_pkg::result_t r;
      r = '0;
      case (c.command)
        lit_pkg::CMD_READ: begin
          n_reads++;
          case (c.reg_index)
            lit_pkg::IDX_ID:   r.read_data = {unit_id, 24'h0};
            lit_pkg::IDX_TPR:  r.read_data = {24'h0, tpr};
            lit_pkg::IDX_SVR:  r.read_data = {23'h0, enabled, spur_vec};
            lit_pkg::IDX_LVT:  r.read_data = {14'h0, periodic, masked, 8'h00, vector};
            lit_pkg::IDX_INIT: r.read_data = 32'(init_cnt);
            lit_pkg::IDX_CUR:  r.read_data = 32'(cur_cnt);
            lit_pkg::IDX_DIV:  r.read_data = {28'h0, div_code};
            default:           r.read_data = 32'h0;
          endcase
        end
        lit_pkg::CMD_WRITE: begin
          n_writes++;
          case (c.reg_index)
            lit_pkg::IDX_TPR: tpr = c.write_data[7:0];
            lit_pkg::IDX_SVR: begin
              spur_vec = c.write_data[7:0];
              enabled  = c.write_data[lit_pkg::SVR_ENABLE_BIT];
            end
            lit_pkg::IDX_LVT: begin
              vector   = c.write_data[7:0];
              masked   = c.write_data[lit_pkg::LVT_MASK_BIT];
              periodic = c.write_data[lit_pkg::LVT_PERIODIC_BIT];
            end
            lit_pkg::IDX_INIT: begin
              init_cnt = c.write_data[lit_pkg::COUNT_WIDTH-1:0];
              cur_cnt  = init_cnt;
              prescale = 7'h00;
            end
            lit_pkg::IDX_DIV: div_code = c.write_data[3:0] & 4'b1011;
            default: ;
          endcase
        end
        lit_pkg::CMD_TICK: begin
          n_ticks++;
          if (cur_cnt != 0) begin
            if (int'(prescale) + 1 >= int'(tick_period())) begin
              prescale = 7'h00;
              cur_cnt  = cur_cnt - {{(lit_pkg::COUNT_WIDTH-1){1'b0}}, 1'b1};
              if (cur_cnt == 0) begin
                if (!masked && enabled) begin
                  r.irq_valid  = 1'b1;
                  r.irq_vector = vector;
                  n_irqs++;
                end
                if (periodic) cur_cnt = init_cnt;
              end
            end else begin
              prescale = prescale + 7'd1;
            end
          end
        end
        default: n_other++;
      endcase
      return r;
    endfunction

    function void note_command(lit_pkg::cmd_t c);
      owed_q.push_back(timer_result(c));
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task check_result(lit_pkg::result_t got);
      lit_pkg::result_t want;
      if (owed_q.size() == 0) begin
        report($sformatf("result beat with nothing owed, read_data %h", got.read_data));
      end else begin
        want = owed_q.pop_front();
        n_checked++;
        if (got.read_data !== want.read_data)
          report($sformatf("beat %0d read_data %h, predicted %h",
                           n_checked, got.read_data, want.read_data));
        if (got.irq_valid !== want.irq_valid)
          report($sformatf("beat %0d irq_valid %b, predicted %b",
                           n_checked, got.irq_valid, want.irq_valid));
        if (got.irq_vector !== want.irq_vector)
          report($sformatf("beat %0d irq_vector %h, predicted %h",
                           n_checked, got.irq_vector, want.irq_vector));
      end
    endtask

    task finish_check();
      if (owed_q.size() != 0)
        report($sformatf("%0d results never came back", owed_q.size()));
    endtask
  endclass

  irq_timer_scoreboard sb;
  int send_idle;
  int recv_idle;
  int hold_left;
  int cycle_cnt = 0;
  int useful_beats = 0;
  int id_settings = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver: random stalls, or a long hold-off counted down here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp_if.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor: every handshake is seen at the rising edge
  always @(posedge clk) begin
    lit_pkg::cmd_t    c;
    lit_pkg::result_t r;
    if (!rst) begin
      // a new beat and a returning result can share an edge; the result
      // always belongs to an older beat, so order here does not matter
      if (cmd_if.valid && cmd_if.ready) begin
        c.command    = lit_pkg::cmd_code_t'(cmd_if.command);
        c.reg_index  = cmd_if.reg_index;
        c.write_data = cmd_if.write_data;
        sb.note_command(c);
      end
      if (rsp_if.valid && rsp_if.ready) begin
        r.read_data  = rsp_if.read_data;
        r.irq_valid  = rsp_if.irq_valid;
        r.irq_vector = rsp_if.irq_vector;
        sb.check_result(r);
      end
      if (cfg_if.valid && cfg_if.ready) begin
        sb.unit_id = cfg_if.data;
        id_settings++;
      end
    end
  end

  function automatic logic [5:0] pick_index();
    if ($urandom_range(99) < 60) begin
      case ($urandom_range(6))
        0:       return lit_pkg::IDX_ID;
        1:       return lit_pkg::IDX_TPR;
        2:       return lit_pkg::IDX_SVR;
        3:       return lit_pkg::IDX_LVT;
        4:       return lit_pkg::IDX_INIT;
        5:       return lit_pkg::IDX_CUR;
        default: return lit_pkg::IDX_DIV;
      endcase
    end
    return 6'($urandom_range(63));
  endfunction

  // offers one beat and returns after the edge that takes it
  task automatic send_beat(input logic [1:0] op, input logic [5:0] idx,
                           input logic [31:0] data);
    bit writable;
    writable = idx inside {lit_pkg::IDX_TPR, lit_pkg::IDX_SVR, lit_pkg::IDX_LVT,
                           lit_pkg::IDX_INIT, lit_pkg::IDX_DIV};
    @(negedge clk);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid      <= 1'b1;
    cmd_if.command    <= op;
    cmd_if.reg_index  <= idx;
    cmd_if.write_data <= data;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    // reserved commands and writes that land nowhere do not count
    if (op != CMD_RESERVED && !(op == lit_pkg::CMD_WRITE && !writable)) useful_beats++;
  endtask

  // stop offering, wait for every owed result, then let the pipe settle
  task automatic drain();
    @(negedge clk) cmd_if.valid <= 1'b0;
    while (sb.owed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_unit_id(input logic [7:0] id);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= id;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk) cfg_if.valid <= 1'b0;
  endtask

  // one timer programming sequence followed by ticks, enough to expire it unless the count is zero or huge
  task automatic timer_scenario();
    logic [31:0] d;
    logic [2:0]  sel;
    int          period;
    int          n;
    int          r;
    d = $urandom;
    d[lit_pkg::SVR_ENABLE_BIT] = ($urandom_range(9) < 8);
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_SVR, d);
    d = $urandom;
    d[lit_pkg::LVT_MASK_BIT] = ($urandom_range(9) < 2);
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_LVT, d);

    // short divisors mostly, the long ones now and then
    r = $urandom_range(99);
    if (r < 35) sel = SEL_DIV_BY_ONE;
    else if (r < 55) sel = 3'd0;
    else if (r < 75) sel = 3'd1;
    else if (r < 93) sel = 3'($urandom_range(2, 5));
    else sel = 3'd6;
    period = (sel == SEL_DIV_BY_ONE) ? 1 : (2 << sel);
    d = $urandom;
    d[3]   = sel[2];
    d[1:0] = sel[1:0];
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_DIV, d);

    // zero stops the timer, a huge count never expires here
    r = $urandom_range(99);
    if (r < 5) d = 32'h0;
    else if (r < 10) d = $urandom;
    else d = $urandom_range(1, (period <= 4) ? 8 : 2);
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_INIT, d);
    n = (r < 10) ? 20 : int'(d) * period * 2 + $urandom_range(0, 4);
    if (n > 300) n = 300;

    while (n > 0) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send_beat(lit_pkg::CMD_READ, pick_index(), $urandom);
      end else if (r < 10) begin
        // divide change mid-count
        send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_DIV, $urandom);
      end else if (r < 11) begin
        // restart
        send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_INIT, $urandom_range(0, 3));
      end else if (r < 12) begin
        send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_LVT, $urandom);
      end else begin
        send_beat(lit_pkg::CMD_TICK, pick_index(), $urandom);
        n--;
      end
    end
  endtask

  task automatic run_phase(input int target, input bit long_hold);
    int  start;
    bit  held;
    start = useful_beats;
    held  = 1'b0;
    while (useful_beats - start < target) begin
      // receiver goes quiet while beats keep coming, so the pipe backs up
      if (long_hold && !held && useful_beats - start > target / 3) begin
        hold_left = LONG_HOLD;
        held = 1'b1;
      end
      if ($urandom_range(99) < 70) timer_scenario();
      else repeat ($urandom_range(1, 8)) send_beat(2'($urandom_range(3)), pick_index(), $urandom);
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cmd_if.valid      = 1'b0;
    cmd_if.command    = lit_pkg::CMD_READ;
    cmd_if.reg_index  = 6'h00;
    cmd_if.write_data = 32'h0;
    rsp_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.data       = 8'h00;
    send_idle = 10;
    recv_idle = 30;
    hold_left = 0;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // directed: reset values, unmodeled index, read-only registers
    send_beat(lit_pkg::CMD_READ, lit_pkg::IDX_ID, 32'h0);
    send_beat(lit_pkg::CMD_READ, lit_pkg::IDX_TPR, 32'h0);
    send_beat(lit_pkg::CMD_READ, lit_pkg::IDX_SVR, 32'h0);
    send_beat(lit_pkg::CMD_READ, lit_pkg::IDX_LVT, 32'h0);
    send_beat(lit_pkg::CMD_READ, lit_pkg::IDX_DIV, 32'h0);
    send_beat(lit_pkg::CMD_READ, 6'h3F, 32'hFFFF_FFFF);
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_TPR, 32'hFFFF_FFFF);
    send_beat(lit_pkg::CMD_READ, lit_pkg::IDX_TPR, 32'h0);
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_ID, 32'hFFFF_FFFF);
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_CUR, 32'hFFFF_FFFF);
    send_beat(lit_pkg::CMD_READ, lit_pkg::IDX_CUR, 32'h0);
    send_beat(CMD_RESERVED, lit_pkg::IDX_TPR, 32'hFFFF_FFFF);
    send_beat(lit_pkg::CMD_TICK, lit_pkg::IDX_INIT, 32'hFFFF_FFFF);   // idle timer
    // enabled unit, unmasked periodic timer, vector ff, divide by one
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_SVR, 32'hFFFF_FFFF);
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_LVT, 32'hFFFE_FFFF);
    send_beat(lit_pkg::CMD_READ, lit_pkg::IDX_LVT, 32'h0);
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_DIV, 32'hFFFF_FFFF);
    send_beat(lit_pkg::CMD_READ, lit_pkg::IDX_DIV, 32'h0);
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_INIT, 32'd2);
    send_beat(lit_pkg::CMD_TICK, 6'h00, 32'h0);
    send_beat(lit_pkg::CMD_TICK, 6'h00, 32'h0);              // expiry and reload
    send_beat(lit_pkg::CMD_READ, lit_pkg::IDX_CUR, 32'h0);
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_INIT, 32'h0);  // zero stops the count
    send_beat(lit_pkg::CMD_TICK, 6'h00, 32'h0);
    send_beat(lit_pkg::CMD_WRITE, lit_pkg::IDX_INIT, 32'hFFFF_FFFF);
    send_beat(lit_pkg::CMD_READ, lit_pkg::IDX_INIT, 32'h0);

    drain();
    write_unit_id(8'hFF);
    send_idle = 26;
    recv_idle = 62;
    run_phase(RANDOM_BEATS / 3, 1'b1);

    drain();
    write_unit_id(8'($urandom_range(1, 254)));
    send_idle = 62;
    recv_idle = 26;
    run_phase(RANDOM_BEATS / 3, 1'b0);

    drain();
    write_unit_id(8'h00);
    send_idle = 0;
    recv_idle = 0;
    run_phase(RANDOM_BEATS - 2 * (RANDOM_BEATS / 3), 1'b1);

    drain();
    sb.finish_check();
    $display("covered %0d reads, %0d writes, %0d ticks, %0d reserved beats, %0d interrupts",
             sb.n_reads, sb.n_writes, sb.n_ticks, sb.n_other, sb.n_irqs);
    $display("%0d results checked across %0d unit id settings, %0d mismatches",
             sb.n_checked, id_settings, sb.errors);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/lit_pkg.sv
rtl/lit_if.sv
rtl/lit_core.sv
rtl/local_interrupt_timer_registers.sv
test/tb_local_interrupt_timer_registers.sv
